// ----- sv/ble_pkg.sv -----
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and codes for the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

	localparam logic [2:0] ACT_PUSH_TAIL  = 3'd0;
	localparam logic [2:0] ACT_POP_BACK   = 3'd1;
	localparam logic [2:0] ACT_PUSH_FRONT = 3'd2;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
	localparam logic [2:0] ACT_INSERT     = 3'd4;
	localparam logic [2:0] ACT_ERASE      = 3'd5;
	localparam logic [2:0] ACT_CLEAR      = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

// ----- sv/ble_ctrl.sv -----
// ----------------------------------------------------------------------------
// ble_ctrl
// Request sequencer: takes one transfer, runs the datapath in S_EXEC,
// and holds the result valid until the receiver takes it.
// ----------------------------------------------------------------------------
module ble_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output ble_pkg::cmd_t  cmd
);

	ble_pkg::state_t state_q;
	logic            out_valid_q;
	logic            fire;

	assign in_ready  = (state_q == ble_pkg::S_IDLE) && (!out_valid_q || out_ready);
	assign fire      = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign cmd.load  = fire;
	assign cmd.exec  = (state_q == ble_pkg::S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ble_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ble_pkg::S_IDLE: begin
					if (fire) state_q <= ble_pkg::S_EXEC;
				end
				ble_pkg::S_EXEC: begin
					state_q <= ble_pkg::S_IDLE;
				end
				default: begin
					state_q <= ble_pkg::S_IDLE;
				end
			endcase
			if (cmd.exec) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- sv/ble_dp.sv -----
// ----------------------------------------------------------------------------
// ble_dp
// List datapath: a row of entry cells that shift toward the tail on insert
// and toward the head on removal, the length register and the result register.
// ----------------------------------------------------------------------------
module ble_dp #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ble_pkg::cmd_t                       cmd,
	input  logic [2:0]                          action,
	input  logic [$clog2(DEPTH+1)-1:0]          position,
	input  logic signed [WORD_BITS-1:0]         value_in,
	output logic signed [WORD_BITS-1:0]         value_out,
	output logic [1:0]                          status,
	output logic [$clog2(DEPTH+1)-1:0]          count
);

	localparam int PW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);

	logic [2:0]                  action_q;
	logic [PW-1:0]               pos_q;
	logic signed [WORD_BITS-1:0] word_q;
	logic [PW-1:0]               len_q;
	logic signed [WORD_BITS-1:0] ent_q [DEPTH];

	logic signed [WORD_BITS-1:0] value_out_q;
	logic [1:0]                  status_q;
	logic [PW-1:0]               count_q;

	logic [1:0]                  st;
	logic                        ins;
	logic                        rem;
	logic                        clr;
	logic [PW-1:0]               ins_pos;
	logic [PW-1:0]               rem_pos;
	logic [PW-1:0]               len_d;
	logic                        full;
	logic                        empty;
	logic signed [WORD_BITS-1:0] removed;

	assign full  = (len_q >= PW'(DEPTH));
	assign empty = (len_q == '0);

	always_comb begin
		st      = ble_pkg::ST_OK;
		ins     = 1'b0;
		rem     = 1'b0;
		clr     = 1'b0;
		ins_pos = len_q;
		rem_pos = len_q - PW'(1);
		unique case (action_q)
			ble_pkg::ACT_PUSH_TAIL: begin
				if (full) st = ble_pkg::ST_FULL;
				else ins = 1'b1;
			end
			ble_pkg::ACT_POP_BACK: begin
				if (empty) st = ble_pkg::ST_EMPTY;
				else rem = 1'b1;
			end
			ble_pkg::ACT_PUSH_FRONT: begin
				ins_pos = '0;
				if (full) st = ble_pkg::ST_FULL;
				else ins = 1'b1;
			end
			ble_pkg::ACT_POP_FRONT: begin
				rem_pos = '0;
				if (empty) st = ble_pkg::ST_EMPTY;
				else rem = 1'b1;
			end
			ble_pkg::ACT_INSERT: begin
				ins_pos = pos_q;
				if (pos_q > len_q) st = ble_pkg::ST_RANGE;
				else if (full) st = ble_pkg::ST_FULL;
				else ins = 1'b1;
			end
			ble_pkg::ACT_ERASE: begin
				rem_pos = pos_q;
				if (empty) st = ble_pkg::ST_EMPTY;
				else if (pos_q >= len_q) st = ble_pkg::ST_RANGE;
				else rem = 1'b1;
			end
			ble_pkg::ACT_CLEAR: begin
				clr = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		len_d = len_q;
		if (clr) len_d = '0;
		else if (ins) len_d = len_q + PW'(1);
		else if (rem) len_d = len_q - PW'(1);
	end

	assign removed = rem ? ent_q[rem_pos[IW-1:0]] : '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			pos_q    <= position;
			word_q   <= value_in;
		end
		if (cmd.exec) begin
			value_out_q <= removed;
			status_q    <= st;
			count_q     <= len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.exec) begin
			len_q <= len_d;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic take_new;
		logic from_lower;
		logic from_upper;

		assign take_new = ins && (ins_pos == PW'(i));
		if (i > 0) begin : g_lo
			assign from_lower = ins && (PW'(i) > ins_pos) && (PW'(i) <= len_q);
		end else begin : g_lo0
			assign from_lower = 1'b0;
		end
		if (i < DEPTH - 1) begin : g_hi
			assign from_upper = rem && (PW'(i) >= rem_pos) && (PW'(i + 1) < len_q);
		end else begin : g_hi0
			assign from_upper = 1'b0;
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (take_new) begin
					ent_q[i] <= word_q;
				end else if (from_lower) begin
					ent_q[i] <= ent_q[(i > 0) ? i - 1 : 0];
				end else if (from_upper) begin
					ent_q[i] <= ent_q[(i < DEPTH - 1) ? i + 1 : DEPTH - 1];
				end
			end
		end
	end

	assign value_out = value_out_q;
	assign status    = status_q;
	assign count     = count_q;

endmodule

// ----- sv/bounded_list_engine_top.sv -----
// ----------------------------------------------------------------------------
// bounded_list_engine_top
// Ordered list of up to DEPTH signed words with push/pop at both ends,
// indexed insert and erase, and clear.
//
// Input channel (in_valid/in_ready): action, position, value_in.
// Output channel (out_valid/out_ready): value_out, status, count, one
// result per input transfer, in order.
// Sequence: a request is registered, then executed, during which every
// entry cell shifts in parallel, and the result is registered; the next
// request is taken in the cycle after the result is written while the
// receiver keeps up, and no new request is taken while one executes.
// Stall: the result register holds until out_ready; a new request is taken
// while a result waits only when that result leaves in the same cycle.
// Reset (arst_n low): the list is emptied and no result is pending; entry
// contents are left as they are and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_list_engine_top #(
	parameter int DEPTH     = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          action,
	input  logic [$clog2(DEPTH+1)-1:0]          position,
	input  logic signed [WORD_BITS-1:0]         value_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [WORD_BITS-1:0]         value_out,
	output logic [1:0]                          status,
	output logic [$clog2(DEPTH+1)-1:0]          count
);

	ble_pkg::cmd_t cmd;

	ble_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ble_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (action),
		.position  (position),
		.value_in  (value_in),
		.value_out (value_out),
		.status    (status),
		.count     (count)
	);

endmodule
